// ===== src/scb_pkg.sv =====
// Package for the scanline Bezier crossing block: coordinate width, register map
// and the packed payload types of the segment and crossing transfers.
// No dependencies.
package scb_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int TQ_BITS     = 16;
    localparam int APB_AW      = 3;

    localparam logic [APB_AW-1:0] ADDR_TOLERANCE = 3'd0;

    typedef struct packed {
        logic                          is_line;
        logic signed [COORD_WIDTH-1:0] begin_x;
        logic signed [COORD_WIDTH-1:0] begin_y;
        logic signed [COORD_WIDTH-1:0] ctrl_x;
        logic signed [COORD_WIDTH-1:0] ctrl_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic signed [COORD_WIDTH-1:0] scan_y;
    } t_segment;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] crossing_x;
        logic                          upward;
        logic                          last;
    } t_crossing;

endpackage

// ===== src/scanline_bezier_crossing.sv =====
// Top level of the scanline Bezier crossing block: a pipelined solver for
// line and quadratic segments with a result serializer. Depends on scb_pkg.
//
// Usage: a segment transfer is taken on a rising edge with start high and busy
// low. After each accepted segment busy goes high and holds off the next segment
// while r_gap counts down; that spacing is set by the single result channel,
// which carries up to three crossings per segment.
// Results leave on o_cross, one per cycle, each marked by o_strobe for exactly
// one cycle; the receiver cannot stall. The last crossing of a segment has
// o_cross.last set. A segment without crossings produces no result.
// The first crossing of a segment is followed by its further crossings in the
// cycles right after it. The path is a 25-stage square root pipeline followed
// by an 18-stage divider pipeline and four interpolation stages; all three
// candidate roots run side by side.
// The APB port holds the degenerate_tolerance register at address 0.
// Reset (synchronous, active low) clears the tolerance and empties the pipe.
module scanline_bezier_crossing (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  scb_pkg::t_segment                  i_seg,
    output logic                               o_strobe,
    output scb_pkg::t_crossing                 o_cross,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [scb_pkg::APB_AW-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int CW    = scb_pkg::COORD_WIDTH;
    localparam int TQ    = scb_pkg::TQ_BITS;
    localparam int NW    = CW + 4;
    localparam int RW    = CW + 1;
    localparam int PW    = 2 * RW;
    localparam int SQN   = RW;
    localparam int QB    = TQ + 2;
    localparam int TW    = TQ + 1;
    localparam int LW    = CW + TW + 2;
    localparam int LANES = 3;

    typedef struct packed {
        logic                 is_line;
        logic                 up0;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] ex;
    } t_geom;

    typedef struct packed {
        t_geom                g;
        logic                 ok0;
        logic                 qok;
        logic signed [NW-1:0] n0;
        logic signed [NW-1:0] d0;
        logic signed [NW-1:0] e;
        logic signed [NW-1:0] ab;
    } t_carry;

    typedef struct packed {
        logic [PW-1:0] rad;
        logic [RW:0]   rem;
        logic [RW-1:0] root;
    } t_sq;

    typedef struct packed {
        logic          ok;
        logic [NW:0]   rem;
        logic [NW-1:0] ud;
        logic [QB-1:0] q;
    } t_div;

    function automatic logic in_unit(input logic signed [NW-1:0] n,
                                     input logic signed [NW-1:0] d,
                                     input logic strict);
        logic r;
        if (d > 0) begin
            r = strict ? (n > 0 && n < d) : (n >= 0 && n <= d);
        end else begin
            r = strict ? (n < 0 && n > d) : (n <= 0 && n >= d);
        end
        return r;
    endfunction

    function automatic t_sq sq_step(input t_sq s);
        t_sq           o;
        logic [RW+2:0] rem2;
        logic [RW+2:0] trial;
        rem2  = {s.rem, s.rad[PW-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        o.rad = {s.rad[PW-3:0], 2'b00};
        if (rem2 >= trial) begin
            rem2   = rem2 - trial;
            o.rem  = rem2[RW:0];
            o.root = {s.root[RW-2:0], 1'b1};
        end else begin
            o.rem  = rem2[RW:0];
            o.root = {s.root[RW-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_div div_init(input logic signed [NW-1:0] n,
                                      input logic signed [NW-1:0] d,
                                      input logic ok);
        t_div                 o;
        logic signed [NW-1:0] nn;
        logic signed [NW-1:0] dd;
        nn   = d[NW-1] ? -n : n;
        dd   = d[NW-1] ? -d : d;
        o.ok  = ok;
        o.rem = {1'b0, nn};
        o.ud  = dd;
        o.q   = '0;
        return o;
    endfunction

    function automatic t_div div_step(input t_div s, input logic first);
        t_div        o;
        logic [NW:0] cand;
        cand = first ? s.rem : {s.rem[NW-1:0], 1'b0};
        o    = s;
        if (cand >= {1'b0, s.ud}) begin
            o.rem = cand - {1'b0, s.ud};
            o.q   = {s.q[QB-2:0], 1'b1};
        end else begin
            o.rem = cand;
            o.q   = {s.q[QB-2:0], 1'b0};
        end
        return o;
    endfunction

    // Round half up of p / 2^TQ, floor based.
    function automatic logic signed [CW:0] rnd(input logic signed [LW-1:0] p);
        logic signed [LW-1:0] s;
        s = (p + (LW'(1) <<< (TQ - 1))) >>> TQ;
        return s[CW:0];
    endfunction

    // Configuration register and input pacing.
    logic [7:0] r_tol;
    logic [1:0] r_gap;
    logic       acc;
    logic       cfg_wr;

    assign acc    = start && !busy;
    assign busy   = (r_gap != 2'd0);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == scb_pkg::ADDR_TOLERANCE);
    assign prdata = (paddr == scb_pkg::ADDR_TOLERANCE) ? {24'd0, r_tol} : 32'd0;

    // Pipeline registers.
    logic              r_a_vld;
    scb_pkg::t_segment r_a_seg;

    logic                 r_b_vld;
    t_carry               r_b_cy;
    logic signed [RW-1:0] r_b_a;
    logic signed [RW-1:0] r_b_b;
    logic signed [RW-1:0] r_b_c;

    logic                 r_c_vld;
    t_carry               r_c_cy;
    logic signed [PW-1:0] r_c_bb;
    logic signed [PW-1:0] r_c_ac;

    logic          r_d_vld;
    t_carry        r_d_cy;
    logic [PW-1:0] r_d_rad;

    logic   r_s_vld [SQN];
    t_carry r_s_cy  [SQN];
    t_sq    r_s_sq  [SQN];

    logic  r_e_vld;
    t_geom r_e_g;
    t_div  r_e_dv [LANES];

    logic  r_v_vld [QB];
    t_geom r_v_g   [QB];
    t_div  r_v_dv  [QB][LANES];

    logic          r_f_vld;
    t_geom         r_f_g;
    logic [TW-1:0] r_f_t  [LANES];
    logic          r_f_ok [LANES];

    logic                 r_g_vld;
    t_geom                r_g_g;
    logic [TW-1:0]        r_g_t  [LANES];
    logic                 r_g_ok [LANES];
    logic signed [LW-1:0] r_g_p0 [LANES];
    logic signed [LW-1:0] r_g_p1 [LANES];

    logic                 r_h_vld;
    t_geom                r_h_g;
    logic [TW-1:0]        r_h_t  [LANES];
    logic                 r_h_ok [LANES];
    logic signed [CW:0]   r_h_p0 [LANES];
    logic signed [CW:0]   r_h_p1 [LANES];

    logic                 r_i_vld;
    t_geom                r_i_g;
    logic                 r_i_ok [LANES];
    logic signed [CW:0]   r_i_p0 [LANES];
    logic signed [LW-1:0] r_i_p2 [LANES];

    logic                 r_j_vld;
    logic                 r_j_up0;
    logic                 r_j_ok [LANES];
    logic signed [CW-1:0] r_j_x  [LANES];

    logic [LANES-1:0]     r_pend;
    logic                 r_lup0;
    logic signed [CW-1:0] r_lx [LANES];
    logic                 r_strobe;
    scb_pkg::t_crossing   r_out;

    // Stage b: differences, linear candidates and the shifted y values.
    logic signed [NW-1:0] by_w, cy_w, ey_w, h_w;
    logic signed [NW-1:0] dy, lnum, ee, ae, cn, cd;
    logic                 lin_en;
    t_carry               n_b_cy;

    always_comb begin
        by_w   = NW'(r_a_seg.begin_y);
        cy_w   = NW'(r_a_seg.ctrl_y);
        ey_w   = NW'(r_a_seg.end_y);
        h_w    = NW'(r_a_seg.scan_y);
        dy     = ey_w - by_w;
        lnum   = h_w - by_w;
        ee     = by_w - (cy_w <<< 1) + ey_w;
        ae     = ee[NW-1] ? -ee : ee;
        cn     = (cy_w <<< 1) - ey_w - h_w;
        cd     = (cy_w - ey_w) <<< 1;
        lin_en = ($unsigned(ae) <= NW'(r_tol)) && (cy_w != ey_w);

        n_b_cy.g.is_line = r_a_seg.is_line;
        n_b_cy.g.up0     = r_a_seg.end_y > r_a_seg.begin_y;
        n_b_cy.g.bx      = r_a_seg.begin_x;
        n_b_cy.g.cx      = r_a_seg.ctrl_x;
        n_b_cy.g.ex      = r_a_seg.end_x;
        if (r_a_seg.is_line) begin
            n_b_cy.ok0 = (dy != '0) && in_unit(lnum, dy, 1'b0);
            n_b_cy.n0  = lnum;
            n_b_cy.d0  = dy;
        end else begin
            n_b_cy.ok0 = lin_en && in_unit(cn, cd, 1'b0);
            n_b_cy.n0  = cn;
            n_b_cy.d0  = cd;
        end
        n_b_cy.qok = !r_a_seg.is_line;
        n_b_cy.e   = ee;
        n_b_cy.ab  = by_w - cy_w;
    end

    // Stage d: discriminant.
    logic signed [PW:0] disc;
    t_carry             n_d_cy;
    assign disc = $signed({r_c_bb[PW-1], r_c_bb}) - $signed({r_c_ac[PW-1], r_c_ac});

    always_comb begin
        n_d_cy     = r_c_cy;
        n_d_cy.qok = r_c_cy.qok && (r_c_cy.e != '0) && !disc[PW];
    end

    // Stage e: both roots of the general quadratic and divider set-up.
    logic signed [NW-1:0] root_w, n1, n2;
    t_carry               e_cy;
    t_div                 n_e_dv [LANES];

    always_comb begin
        e_cy      = r_s_cy[SQN-1];
        root_w    = $signed(NW'(r_s_sq[SQN-1].root));
        n1        = e_cy.ab + root_w;
        n2        = e_cy.ab - root_w;
        n_e_dv[0] = div_init(e_cy.n0, e_cy.d0, e_cy.ok0);
        n_e_dv[1] = div_init(n1, e_cy.e, e_cy.qok && in_unit(n1, e_cy.e, 1'b1));
        n_e_dv[2] = div_init(n2, e_cy.e, e_cy.qok && in_unit(n2, e_cy.e, 1'b1));
    end

    // Stages f to j: t rounding and the de Casteljau interpolation.
    logic [QB:0]          qp     [LANES];
    logic signed [TW:0]   tt_g   [LANES];
    logic signed [TW:0]   tt_i   [LANES];
    logic signed [CW:0]   qa     [LANES];
    logic signed [CW:0]   d0g    [LANES];
    logic signed [CW:0]   d1g    [LANES];
    logic signed [CW:0]   dh     [LANES];
    logic signed [CW:0]   xj     [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            qp[l]   = {1'b0, r_v_dv[QB-1][l].q} + 1'b1;
            tt_g[l] = $signed({1'b0, r_f_t[l]});
            tt_i[l] = $signed({1'b0, r_h_t[l]});
            qa[l]   = r_f_g.is_line ? (CW+1)'(r_f_g.ex) : (CW+1)'(r_f_g.cx);
            d0g[l]  = qa[l] - (CW+1)'(r_f_g.bx);
            d1g[l]  = (CW+1)'(r_f_g.ex) - (CW+1)'(r_f_g.cx);
            dh[l]   = r_h_p1[l] - r_h_p0[l];
            // Interpolated points stay between their end points, so no
            // saturation is ever needed on the final value.
            xj[l]   = r_i_g.is_line ? r_i_p0[l] : r_i_p0[l] + rnd(r_i_p2[l]);
        end
    end

    // Output serializer: lowest pending lane first.
    logic [LANES-1:0]     sel;
    logic [LANES-1:0]     rest;
    logic [LANES-1:0]     n_pend;
    scb_pkg::t_crossing   n_out;

    always_comb begin
        if (r_pend[0]) begin
            sel = 3'b001;
        end else if (r_pend[1]) begin
            sel = 3'b010;
        end else if (r_pend[2]) begin
            sel = 3'b100;
        end else begin
            sel = 3'b000;
        end
        rest = r_pend & ~sel;
        n_out.crossing_x = sel[0] ? r_lx[0] : (sel[1] ? r_lx[1] : r_lx[2]);
        n_out.upward     = sel[0] ? r_lup0 : sel[1];
        n_out.last       = (rest == '0);
        n_pend = r_j_vld ? {r_j_ok[2], r_j_ok[1], r_j_ok[0]} : rest;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= '0;
            r_gap    <= '0;
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_c_vld  <= 1'b0;
            r_d_vld  <= 1'b0;
            r_e_vld  <= 1'b0;
            r_f_vld  <= 1'b0;
            r_g_vld  <= 1'b0;
            r_h_vld  <= 1'b0;
            r_i_vld  <= 1'b0;
            r_j_vld  <= 1'b0;
            r_pend   <= '0;
            r_strobe <= 1'b0;
            for (int k = 0; k < SQN; k++) begin
                r_s_vld[k] <= 1'b0;
            end
            for (int j = 0; j < QB; j++) begin
                r_v_vld[j] <= 1'b0;
            end
        end else begin
            if (cfg_wr) begin
                r_tol <= pwdata[7:0];
            end
            if (acc) begin
                r_gap <= 2'd2;
            end else if (r_gap != 2'd0) begin
                r_gap <= r_gap - 2'd1;
            end
            r_a_vld <= acc;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_s_vld[0] <= r_d_vld;
            for (int k = 1; k < SQN; k++) begin
                r_s_vld[k] <= r_s_vld[k-1];
            end
            r_e_vld <= r_s_vld[SQN-1];
            r_v_vld[0] <= r_e_vld;
            for (int j = 1; j < QB; j++) begin
                r_v_vld[j] <= r_v_vld[j-1];
            end
            r_f_vld  <= r_v_vld[QB-1];
            r_g_vld  <= r_f_vld;
            r_h_vld  <= r_g_vld;
            r_i_vld  <= r_h_vld;
            r_j_vld  <= r_i_vld;
            r_pend   <= n_pend;
            r_strobe <= (sel != '0);
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_seg <= i_seg;
        end
        r_b_cy <= n_b_cy;
        r_b_a  <= $signed(by_w[RW-1:0] - h_w[RW-1:0]);
        r_b_b  <= $signed(cy_w[RW-1:0] - h_w[RW-1:0]);
        r_b_c  <= $signed(ey_w[RW-1:0] - h_w[RW-1:0]);

        r_c_cy <= r_b_cy;
        r_c_bb <= r_b_b * r_b_b;
        r_c_ac <= r_b_a * r_b_c;

        r_d_cy  <= n_d_cy;
        r_d_rad <= disc[PW-1:0];

        r_s_cy[0] <= r_d_cy;
        r_s_sq[0] <= sq_step(t_sq'{rad: r_d_rad, rem: '0, root: '0});
        for (int k = 1; k < SQN; k++) begin
            r_s_cy[k] <= r_s_cy[k-1];
            r_s_sq[k] <= sq_step(r_s_sq[k-1]);
        end

        r_e_g <= e_cy.g;
        for (int l = 0; l < LANES; l++) begin
            r_e_dv[l] <= n_e_dv[l];
        end

        r_v_g[0] <= r_e_g;
        for (int l = 0; l < LANES; l++) begin
            r_v_dv[0][l] <= div_step(r_e_dv[l], 1'b1);
        end
        for (int j = 1; j < QB; j++) begin
            r_v_g[j] <= r_v_g[j-1];
            for (int l = 0; l < LANES; l++) begin
                r_v_dv[j][l] <= div_step(r_v_dv[j-1][l], 1'b0);
            end
        end

        r_f_g <= r_v_g[QB-1];
        r_g_g <= r_f_g;
        r_h_g <= r_g_g;
        r_i_g <= r_h_g;
        r_j_up0 <= r_i_g.up0;
        for (int l = 0; l < LANES; l++) begin
            r_f_t[l]  <= qp[l][TW:1];
            r_f_ok[l] <= r_v_dv[QB-1][l].ok;

            r_g_t[l]  <= r_f_t[l];
            r_g_ok[l] <= r_f_ok[l];
            r_g_p0[l] <= d0g[l] * tt_g[l];
            r_g_p1[l] <= d1g[l] * tt_g[l];

            r_h_t[l]  <= r_g_t[l];
            r_h_ok[l] <= r_g_ok[l];
            r_h_p0[l] <= (CW+1)'(r_g_g.bx) + rnd(r_g_p0[l]);
            r_h_p1[l] <= (CW+1)'(r_g_g.cx) + rnd(r_g_p1[l]);

            r_i_ok[l] <= r_h_ok[l];
            r_i_p0[l] <= r_h_p0[l];
            r_i_p2[l] <= dh[l] * tt_i[l];

            r_j_ok[l] <= r_i_ok[l];
            r_j_x[l]  <= xj[l][CW-1:0];
        end

        if (r_j_vld) begin
            r_lup0 <= r_j_up0;
            for (int l = 0; l < LANES; l++) begin
                r_lx[l] <= r_j_x[l];
            end
        end
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_cross  = r_out;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> busy)
        else $error("segment accepted without holding off the next one");

    a_results_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_cross.last |=> o_strobe)
        else $error("crossings of one segment were not sent back to back");

    a_serializer_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j_vld |-> $countones(r_pend) <= 1)
        else $error("new segment reached the serializer while it was still full");

    a_pipe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j_vld |-> !r_i_vld && !r_h_vld)
        else $error("segments in the pipeline closer than three cycles");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for scanline_bezier_crossing: directed and random segments
// against an in-bench crossing predictor, plus APB writes of the tolerance register.
// Depends on scb_pkg and the scanline_bezier_crossing RTL.
module testbench;

    localparam int DRAIN_CYCLES = 70;
    localparam int STALL_LIMIT  = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    scb_pkg::t_segment  i_seg;
    logic        o_strobe;
    scb_pkg::t_crossing o_cross;
    logic        psel, penable, pwrite, pready;
    logic [scb_pkg::APB_AW-1:0] paddr;
    logic [31:0] pwdata, prdata;

    scb_pkg::t_crossing expected_crossings[$];
    logic [7:0]  tolerance;
    int          errors = 0;
    int          segments_sent = 0;
    int          crossings_seen = 0;
    int          idle_cycles = 0;

    scanline_bezier_crossing dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_seg(i_seg),
        .o_strobe(o_strobe), .o_cross(o_cross), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- crossing predictor ----------------
    function automatic bit t_in_range(longint n, longint d, bit strict);
        if (d > 0)
            return strict ? (n > 0 && n < d) : (n >= 0 && n <= d);
        return strict ? (n < 0 && n > d) : (n <= 0 && n >= d);
    endfunction

    function automatic longint quantize_t(longint n, longint d);
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        return ((n <<< (scb_pkg::TQ_BITS + 1)) + d) / (d * 2);
    endfunction

    function automatic longint interp(longint p, longint q, longint t);
        return p + (((q - p) * t + (longint'(1) <<< (scb_pkg::TQ_BITS - 1)))
                    >>> scb_pkg::TQ_BITS);
    endfunction

    function automatic longint curve_point_x(longint bx, longint cx, longint ex, longint t);
        return interp(interp(bx, cx, t), interp(cx, ex, t), t);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    task automatic add_crossing(longint x, bit up);
        scb_pkg::t_crossing c;
        longint hi, lo;
        hi = (longint'(1) <<< (scb_pkg::COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        c.crossing_x = x[scb_pkg::COORD_WIDTH-1:0];
        c.upward = up;
        c.last = 1'b0;
        expected_crossings.insert(expected_crossings.size(), c);
    endtask

    task automatic predict_crossings(scb_pkg::t_segment s);
        longint bx, by, cx, cy, ex, ey, h, e, ae, a0, b0, c0, disc, root, n1, n2;
        int before_count;
        bx = s.begin_x; by = s.begin_y; cx = s.ctrl_x; cy = s.ctrl_y;
        ex = s.end_x;   ey = s.end_y;   h = s.scan_y;
        before_count = expected_crossings.size();
        if (s.is_line) begin
            if (ey != by && t_in_range(h - by, ey - by, 1'b0))
                add_crossing(interp(bx, ex, quantize_t(h - by, ey - by)), ey > by);
        end else begin
            e = by - 2 * cy + ey;
            ae = (e < 0) ? -e : e;
            // Near-flat curves also get the linear solve; both paths may fire.
            if (ae <= longint'(tolerance) && cy != ey &&
                t_in_range(2 * cy - ey - h, 2 * (cy - ey), 1'b0))
                add_crossing(curve_point_x(bx, cx, ex,
                    quantize_t(2 * cy - ey - h, 2 * (cy - ey))), ey > by);
            a0 = by - h; b0 = cy - h; c0 = ey - h;
            disc = b0 * b0 - a0 * c0;
            if (e != 0 && disc >= 0) begin
                root = int_sqrt(disc);
                n1 = a0 - b0 + root;
                n2 = a0 - b0 - root;
                if (t_in_range(n1, e, 1'b1))
                    add_crossing(curve_point_x(bx, cx, ex, quantize_t(n1, e)), 1'b1);
                if (t_in_range(n2, e, 1'b1))
                    add_crossing(curve_point_x(bx, cx, ex, quantize_t(n2, e)), 1'b0);
            end
        end
        if (expected_crossings.size() > before_count)
            expected_crossings[$].last = 1'b1;
    endtask

    // ---------------- drivers ----------------
    task automatic send_segment(scb_pkg::t_segment s);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_seg <= s;
        do @(posedge i_clk); while (busy);
        predict_crossings(s);
        segments_sent++;
    endtask

    task automatic end_stream();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        end_stream();
        wait (expected_crossings.size() == 0);
        // Segments without crossings may still be in flight.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [7:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= scb_pkg::ADDR_TOLERANCE; pwdata <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tolerance = value;
        @(negedge i_clk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== value) begin
            $display("%0t: tolerance readback expected %0d actual %0d", $time, value,
                     prdata[7:0]);
            errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    function automatic scb_pkg::t_segment make_segment(bit line, int bx, int by, int cx,
                                                       int cy, int ex, int ey, int h);
        scb_pkg::t_segment s;
        s.is_line = line;
        s.begin_x = bx; s.begin_y = by; s.ctrl_x = cx; s.ctrl_y = cy;
        s.end_x = ex;   s.end_y = ey;   s.scan_y = h;
        return s;
    endfunction

    function automatic int rand_coord(bit wide);
        if (wide) return int'($urandom);
        return $urandom_range(0, 16384) - 8192;
    endfunction

    // ---------------- tests ----------------
    task automatic test_lines();
        send_segment(make_segment(1, 0, 0, 0, 0, 2560, 2560, 1280));
        send_segment(make_segment(1, 100, 500, 0, 0, 900, -500, 0));
        send_segment(make_segment(1, 7, 0, 0, 0, 99, 1000, 0));       // crossing at t = 0
        send_segment(make_segment(1, 7, 0, 0, 0, 99, 1000, 1000));    // crossing at t = 1
        send_segment(make_segment(1, 0, 300, 0, 0, 4000, 300, 300)); // horizontal
        send_segment(make_segment(1, 0, 0, 0, 0, 10, 10, 11));        // misses
        send_segment(make_segment(1, -8388608, -8388608, 5, 5, 8388607, 8388607, 0));
        send_segment(make_segment(1, 8388607, 8388607, 0, 0, -8388608, -8388608, -1));
        send_segment(make_segment(1, 1, -8388608, 0, 0, 3, 8388607, 8388607));
    endtask

    task automatic test_curves();
        send_segment(make_segment(0, 0, 0, 1000, 4000, 2000, 0, 1000));     // two roots
        send_segment(make_segment(0, 0, 0, 1000, -4000, 2000, 0, -1000));
        send_segment(make_segment(0, 0, 0, 1000, 4000, 2000, 0, 5000));     // negative disc
        send_segment(make_segment(0, 0, 0, 1000, 4000, 2000, 0, 2000));     // tangent
        send_segment(make_segment(0, 0, 0, 500, 256, 1000, 512, 100));      // flat, e = 0
        send_segment(make_segment(0, -8388608, -8388608, 8388607, 8388607,
                                  -8388608, -8388608, 0));
        send_segment(make_segment(0, 8388607, 8388607, -8388608, -8388608,
                                  8388607, 8388607, 8388607));
        send_segment(make_segment(0, 3, 0, 9, 500, 12, 500, 300));          // ctrl_y == end_y
    endtask

    task automatic test_degenerate(logic [7:0] tol);
        wait_drained();
        write_tolerance(tol);
        send_segment(make_segment(0, 0, 0, 800, 256, 1600, 513, 300));    // e = 1
        send_segment(make_segment(0, 0, 0, 800, 200, 1600, 655, 400));    // e = 255
        send_segment(make_segment(0, 0, 600, 800, 0, 1600, 600, 100));    // misses, negative disc
    endtask

    task automatic test_random(int count, bit wide_mix);
        scb_pkg::t_segment s;
        int lo_y, hi_y;
        repeat (count) begin
            s = make_segment($urandom_range(0, 1), rand_coord(0), rand_coord(0), rand_coord(0),
                             rand_coord(0), rand_coord(0), rand_coord(0), 0);
            if (wide_mix && $urandom_range(0, 3) == 0) begin
                s = $urandom;
                s.begin_x = $urandom; s.begin_y = $urandom; s.ctrl_x = $urandom;
                s.ctrl_y = $urandom; s.end_x = $urandom; s.end_y = $urandom;
                s.scan_y = $urandom;
            end else if ($urandom_range(0, 4) != 0) begin
                // Put the scanline inside the vertical extent of the segment's control points.
                lo_y = s.begin_y < s.end_y ? s.begin_y : s.end_y;
                hi_y = s.begin_y < s.end_y ? s.end_y : s.begin_y;
                if (!s.is_line && s.ctrl_y < lo_y) lo_y = s.ctrl_y;
                if (!s.is_line && s.ctrl_y > hi_y) hi_y = s.ctrl_y;
                s.scan_y = lo_y + int'($urandom_range(0, hi_y - lo_y));
            end else begin
                s.scan_y = rand_coord(0);
            end
            send_segment(s);
        end
    endtask

    // ---------------- checking ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            crossings_seen++;
            if (expected_crossings.size() == 0) begin
                $display("%0t: unexpected crossing x=%0d up=%0b last=%0b", $time,
                         o_cross.crossing_x, o_cross.upward, o_cross.last);
                errors++;
            end else begin
                scb_pkg::t_crossing want;
                want = expected_crossings.pop_front();
                if (o_cross.crossing_x !== want.crossing_x) begin
                    $display("%0t: crossing_x expected %0d actual %0d", $time,
                             want.crossing_x, o_cross.crossing_x);
                    errors++;
                end
                if (o_cross.upward !== want.upward) begin
                    $display("%0t: upward expected %0b actual %0b", $time,
                             want.upward, o_cross.upward);
                    errors++;
                end
                if (o_cross.last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             want.last, o_cross.last);
                    errors++;
                end
            end
        end
    end

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if (o_strobe || (start && !busy) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d crossings outstanding", $time,
                     expected_crossings.size());
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        start = 1'b0; i_seg = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        tolerance = 8'd0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_lines();
        test_curves();
        test_degenerate(8'd1);
        test_degenerate(8'd255);
        wait_drained();
        write_tolerance(8'd0);
        test_random(30, 1'b1);
        wait_drained();
        write_tolerance($urandom_range(1, 254));
        test_random(25, 1'b1);
        wait_drained();
        write_tolerance(8'd255);
        test_random(22, 1'b0);
        wait_drained();

        $display("Covered %0d segments (lines, curves, near-flat curves) giving %0d crossings,",
                 segments_sent, crossings_seen);
        $display("with tolerance at 0, 1, mid-range and 255 and random gaps between segments.");
        if (errors == 0 && expected_crossings.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d mismatches, %0d crossings missing", errors, expected_crossings.size());
            $display("testbench failed");
        end
        $finish;
    end
endmodule
